[design/quaternion_slerp_top_macros.svh]
// Assertion macros for the quaternion slerp block.
// Define NO_ASSERTIONS to compile every check away.
`ifndef QUATERNION_SLERP_TOP_MACROS_SVH
`define QUATERNION_SLERP_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QS_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QS_ASSERT(label, prop, msg)
`define QS_ASSERT_NOW(label, prop, msg)
`endif
`endif

[design/qslerp_pkg.sv]
// Types, sizes, stage map and arctangent table for the quaternion slerp block.
// No dependencies; used by quaternion_slerp_top and its testbench.
`timescale 1ns / 1ps

package qslerp_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int COMP_W       = 16;
    localparam int BLEND_W      = 15;
    localparam int B_W          = COMP_W + 1;
    localparam int ONE          = 1 << FRAC_BITS;

    // slerp threshold, round(0.9999 * 2^F)
    localparam longint THR_SCALED = longint'(9999) << FRAC_BITS;
    localparam int THR = int'(THR_SCALED / 10000) + ((THR_SCALED % 10000 >= 5000) ? 1 : 0);

    localparam int PROD_W  = 2 * COMP_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int C_W     = DOT_W - 1 - FRAC_BITS;
    localparam int SQ_BITS = FRAC_BITS + 1;
    localparam int RAD_W   = 2 * FRAC_BITS + 1;
    localparam int TRIAL_W = 2 * SQ_BITS + 1;
    localparam int CW      = FRAC_BITS + 4;
    localparam int MAG_W   = CW - 1;
    localparam int NUM_W   = MAG_W + FRAC_BITS;
    localparam int DEN_W   = CW - 1;
    localparam int WT_W    = NUM_W + 1;
    localparam int PA_W    = COMP_W + WT_W;
    localparam int PB_W    = B_W + WT_W;
    localparam int ACC_W   = PB_W + 1;

    // stage map
    localparam int S_IN      = 0;
    localparam int S_DOT     = 1;
    localparam int S_RAD     = 2;
    localparam int S_SQ0     = 3;
    localparam int S_SQ_LAST = S_SQ0 + SQ_BITS - 1;
    localparam int S_AT0     = S_SQ_LAST + 1;
    localparam int S_AT_LAST = S_AT0 + CORDIC_STEPS - 1;
    localparam int S_TW      = S_AT_LAST + 1;
    localparam int S_SN0     = S_TW + 1;
    localparam int S_SN_LAST = S_SN0 + CORDIC_STEPS - 1;
    localparam int S_DV0     = S_SN_LAST + 1;
    localparam int S_DV_LAST = S_DV0 + NUM_W - 1;
    localparam int S_WT      = S_DV_LAST + 1;
    localparam int S_OUT     = S_WT + 1;
    localparam int NST       = S_OUT + 1;

    typedef struct packed {
        logic signed [COMP_W-1:0] a_x;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] a_w;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_z;
        logic signed [COMP_W-1:0] b_w;
        logic        [BLEND_W-1:0] blend;
    } item_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
        logic                     used_linear;
    } result_t;

    // operands that ride along the whole pipeline
    typedef struct packed {
        logic [3:0][COMP_W-1:0] a;
        logic [3:0][B_W-1:0]    b;
        logic [BLEND_W-1:0]     t;
        logic                   lin;
    } side_t;

    // atan(2^-i) in angle units of 2^-F, rounded half up from a 2^-30 table
    function automatic logic signed [CW-1:0] atan_step(input int i);
        longint v;
        int     sh;
        sh = 30 - FRAC_BITS;
        case (i)
            0:  v = 843314857;
            1:  v = 497837829;
            2:  v = 263043837;
            3:  v = 133525159;
            4:  v = 67021687;
            5:  v = 33543516;
            6:  v = 16775851;
            7:  v = 8388437;
            8:  v = 4194283;
            9:  v = 2097149;
            10: v = 1048576;
            default: v = (i <= 30) ? (longint'(1) << (30 - i)) : longint'(0);
        endcase
        if (sh > 0)
        begin
            v = (v + (longint'(1) << (sh - 1))) >> sh;
        end
        return CW'(v);
    endfunction

endpackage

[design/quaternion_slerp_top.sv]
// Quaternion slerp, fully pipelined top level.
// Depends on qslerp_pkg and quaternion_slerp_top_macros.svh.
`timescale 1ns / 1ps

// Takes one transaction per clock unless stalled and returns each result in
// order. The pipeline sections are the dot product and short-arc fold, a
// square root that settles one bit per stage, a 16-step CORDIC arctangent,
// three 16-step CORDIC sine lanes side by side, a 31-stage restoring divider
// pair for the weights, and two stages of weighted sums with rounding and
// saturation. A stall on the result side while a result is valid freezes the
// entire pipeline in place, so item_stall rises in the same cycle; nothing is
// lost or repeated. No clearing pass is needed after reset.
module quaternion_slerp_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  qslerp_pkg::item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output qslerp_pkg::result_t result
);
    import qslerp_pkg::*;
`include "quaternion_slerp_top_macros.svh"

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (COMP_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(1 << (COMP_W - 1));
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1 << (FRAC_BITS - 1));

    logic                      en;
    logic [NST-1:0]            vld_reg, vld_next;
    side_t                     side_reg  [S_IN:S_WT];
    side_t                     side_next [S_IN:S_WT];
    side_t                     in_side, dot_side, dv_side;

    logic signed [PROD_W-1:0]  prod_reg [4], prod_next [4];
    logic [FRAC_BITS-1:0]      c_reg [S_DOT:S_SQ_LAST], c_next [S_DOT:S_SQ_LAST];
    logic [RAD_W-1:0]          sq_rem_reg  [S_RAD:S_SQ_LAST], sq_rem_next  [S_RAD:S_SQ_LAST];
    logic [SQ_BITS-1:0]        sq_root_reg [S_RAD:S_SQ_LAST], sq_root_next [S_RAD:S_SQ_LAST];
    logic signed [CW-1:0]      cx_reg [S_AT0:S_AT_LAST], cx_next [S_AT0:S_AT_LAST];
    logic signed [CW-1:0]      cy_reg [S_AT0:S_AT_LAST], cy_next [S_AT0:S_AT_LAST];
    logic signed [CW-1:0]      cz_reg [S_AT0:S_AT_LAST], cz_next [S_AT0:S_AT_LAST];
    logic signed [CW-1:0]      zs_reg [3], zs_next [3];
    logic signed [CW-1:0]      sx_reg [S_SN0:S_SN_LAST][3], sx_next [S_SN0:S_SN_LAST][3];
    logic signed [CW-1:0]      sy_reg [S_SN0:S_SN_LAST][3], sy_next [S_SN0:S_SN_LAST][3];
    logic signed [CW-1:0]      sz_reg [S_SN0:S_SN_LAST][3], sz_next [S_SN0:S_SN_LAST][3];
    logic [NUM_W-1:0]          dv_num_reg [S_DV0:S_DV_LAST][2];
    logic [NUM_W-1:0]          dv_num_next [S_DV0:S_DV_LAST][2];
    logic [DEN_W-1:0]          dv_rem_reg [S_DV0:S_DV_LAST][2];
    logic [DEN_W-1:0]          dv_rem_next [S_DV0:S_DV_LAST][2];
    logic                      dv_sgn_reg [S_DV0:S_DV_LAST][2];
    logic                      dv_sgn_next [S_DV0:S_DV_LAST][2];
    logic [DEN_W-1:0]          dv_den_reg [S_DV0:S_DV_LAST], dv_den_next [S_DV0:S_DV_LAST];
    logic signed [PA_W-1:0]    pa_reg [4], pa_next [4];
    logic signed [PB_W-1:0]    pb_reg [4], pb_next [4];
    result_t                   res_reg, res_next;

    logic signed [DOT_W-1:0]   dot;
    logic                      dot_neg;
    logic [DOT_W-2:0]          dot_mag;
    logic [C_W-1:0]            c_full;
    logic signed [CW-1:0]      omega, tw;
    logic signed [CW+BLEND_W:0] tw_prod;
    logic signed [CW-1:0]      sin_o;
    logic [MAG_W-1:0]          sin_mag [2];

    // advance the whole pipeline unless the result register is held
    assign en           = !(vld_reg[S_OUT] && result_stall);
    assign item_stall   = !en;
    assign result_valid = vld_reg[S_OUT];
    assign result       = res_reg;
    assign vld_next     = {vld_reg[NST-2:0], item_valid};

    // capture the transaction, clamp blend, widen b
    always_comb
    begin
        in_side.a[0] = item.a_x;
        in_side.a[1] = item.a_y;
        in_side.a[2] = item.a_z;
        in_side.a[3] = item.a_w;
        in_side.b[0] = B_W'(item.b_x);
        in_side.b[1] = B_W'(item.b_y);
        in_side.b[2] = B_W'(item.b_z);
        in_side.b[3] = B_W'(item.b_w);
        in_side.t    = (item.blend > BLEND_W'(ONE)) ? BLEND_W'(ONE) : item.blend;
        in_side.lin  = 1'b0;
        prod_next[0] = item.a_x * item.b_x;
        prod_next[1] = item.a_y * item.b_y;
        prod_next[2] = item.a_z * item.b_z;
        prod_next[3] = item.a_w * item.b_w;
    end

    // sum the dot product, fold to the short arc, test the threshold
    assign dot     = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1])
                   + DOT_W'(prod_reg[2]) + DOT_W'(prod_reg[3]);
    assign dot_neg = dot[DOT_W-1];
    assign dot_mag = dot_neg ? (DOT_W-1)'(-dot) : (DOT_W-1)'(dot);
    assign c_full  = dot_mag[DOT_W-2:FRAC_BITS];

    always_comb
    begin
        dot_side = side_reg[S_IN];
        for (int k = 0; k < 4; k++)
        begin
            if (dot_neg)
            begin
                dot_side.b[k] = B_W'(-$signed(side_reg[S_IN].b[k]));
            end
        end
        dot_side.lin = (c_full >= C_W'(THR));
    end
    assign c_next[S_DOT] = c_full[FRAC_BITS-1:0];

    // radicand 1 - c^2
    assign sq_rem_next[S_RAD]  = (RAD_W'(1) << (2 * FRAC_BITS))
                               - (RAD_W'(c_reg[S_DOT]) * RAD_W'(c_reg[S_DOT]));
    assign sq_root_next[S_RAD] = '0;
    assign c_next[S_RAD]       = c_reg[S_DOT];

    // square root, one result bit per stage
    for (genvar j = 0; j < SQ_BITS; j++)
    begin : g_sqrt
        localparam int S = S_SQ0 + j;
        localparam int K = SQ_BITS - 1 - j;
        logic [TRIAL_W-1:0] trial;
        logic               take;
        assign trial = ((TRIAL_W'(sq_root_reg[S-1]) << 1) + (TRIAL_W'(1) << K)) << K;
        assign take  = trial <= TRIAL_W'(sq_rem_reg[S-1]);
        assign sq_rem_next[S]  = take ? RAD_W'(TRIAL_W'(sq_rem_reg[S-1]) - trial)
                                      : sq_rem_reg[S-1];
        assign sq_root_next[S] = take ? (sq_root_reg[S-1] | (SQ_BITS'(1) << K))
                                      : sq_root_reg[S-1];
        assign c_next[S]       = c_reg[S-1];
    end

    // CORDIC vectoring: omega = atan2(sin, cos)
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_atan
        localparam int S = S_AT0 + i;
        localparam logic signed [CW-1:0] AT = atan_step(i);
        logic signed [CW-1:0] xi, yi, zi;
        if (i == 0)
        begin : g_first
            assign xi = $signed(CW'(c_reg[S_SQ_LAST]));
            assign yi = $signed(CW'(sq_root_reg[S_SQ_LAST]));
            assign zi = '0;
        end
        else
        begin : g_next
            assign xi = cx_reg[S-1];
            assign yi = cy_reg[S-1];
            assign zi = cz_reg[S-1];
        end
        assign cx_next[S] = (yi >= 0) ? xi + (yi >>> i) : xi - (yi >>> i);
        assign cy_next[S] = (yi >= 0) ? yi - (xi >>> i) : yi + (xi >>> i);
        assign cz_next[S] = (yi >= 0) ? zi + AT : zi - AT;
    end

    // split omega into (1-t)omega, t omega and omega
    assign omega      = cz_reg[S_AT_LAST];
    assign tw_prod    = omega * $signed({1'b0, side_reg[S_AT_LAST].t});
    assign tw         = CW'(tw_prod >>> FRAC_BITS);
    assign zs_next[0] = omega - tw;
    assign zs_next[1] = tw;
    assign zs_next[2] = omega;

    // three CORDIC rotation lanes for the sines
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_sin
        localparam int S = S_SN0 + i;
        localparam logic signed [CW-1:0] AT = atan_step(i);
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic signed [CW-1:0] xi, yi, zi;
            if (i == 0)
            begin : g_first
                assign xi = CW'(ONE);
                assign yi = '0;
                assign zi = zs_reg[l];
            end
            else
            begin : g_next
                assign xi = sx_reg[S-1][l];
                assign yi = sy_reg[S-1][l];
                assign zi = sz_reg[S-1][l];
            end
            assign sx_next[S][l] = (zi >= 0) ? xi - (yi >>> i) : xi + (yi >>> i);
            assign sy_next[S][l] = (zi >= 0) ? yi + (xi >>> i) : yi - (xi >>> i);
            assign sz_next[S][l] = (zi >= 0) ? zi - AT : zi + AT;
        end
    end

    // drop to linear weights when sin(omega) is not positive
    assign sin_o = sy_reg[S_SN_LAST][2];
    always_comb
    begin
        dv_side     = side_reg[S_DV0-1];
        dv_side.lin = side_reg[S_DV0-1].lin | !(sin_o > 0);
    end

    // weight dividers: |sin| * 2^F / sin(omega), one quotient bit per stage
    for (genvar l = 0; l < 2; l++)
    begin : g_mag
        logic signed [CW-1:0] sv;
        assign sv         = sy_reg[S_SN_LAST][l];
        assign sin_mag[l] = (sv < 0) ? MAG_W'(-sv) : MAG_W'(sv);
    end

    for (genvar j = 0; j < NUM_W; j++)
    begin : g_div
        localparam int S = S_DV0 + j;
        logic [DEN_W-1:0] di;
        if (j == 0)
        begin : g_first
            assign di = sin_o[DEN_W-1:0];
        end
        else
        begin : g_next
            assign di = dv_den_reg[S-1];
        end
        assign dv_den_next[S] = di;
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [NUM_W-1:0] ni;
            logic [DEN_W-1:0] ri;
            logic             si;
            logic [DEN_W:0]   cand;
            logic             ge;
            if (j == 0)
            begin : g_first
                assign ni = {sin_mag[l], FRAC_BITS'(0)};
                assign ri = '0;
                assign si = sy_reg[S_SN_LAST][l][CW-1];
            end
            else
            begin : g_next
                assign ni = dv_num_reg[S-1][l];
                assign ri = dv_rem_reg[S-1][l];
                assign si = dv_sgn_reg[S-1][l];
            end
            assign cand = {ri, ni[NUM_W-1]};
            assign ge   = cand >= {1'b0, di};
            assign dv_rem_next[S][l] = ge ? DEN_W'(cand - {1'b0, di}) : DEN_W'(cand);
            assign dv_num_next[S][l] = {ni[NUM_W-2:0], ge};
            assign dv_sgn_next[S][l] = si;
        end
    end

    // advance the side operands, updating them where a stage decides something
    for (genvar j = S_IN; j <= S_WT; j++)
    begin : g_side
        if (j == S_IN)
        begin : g_in
            assign side_next[j] = in_side;
        end
        else if (j == S_DOT)
        begin : g_dot
            assign side_next[j] = dot_side;
        end
        else if (j == S_DV0)
        begin : g_dv
            assign side_next[j] = dv_side;
        end
        else
        begin : g_pass
            assign side_next[j] = side_reg[j-1];
        end
    end

    // pick the weights and form the products
    always_comb
    begin
        logic signed [WT_W-1:0] q0, q1, w0, w1, t_ext;
        side_t                  sd;
        sd    = side_reg[S_DV_LAST];
        t_ext = $signed({(WT_W - BLEND_W)'(0), sd.t});
        q0    = $signed({1'b0, dv_num_reg[S_DV_LAST][0]});
        q1    = $signed({1'b0, dv_num_reg[S_DV_LAST][1]});
        if (dv_sgn_reg[S_DV_LAST][0])
        begin
            q0 = -q0;
        end
        if (dv_sgn_reg[S_DV_LAST][1])
        begin
            q1 = -q1;
        end
        w0 = sd.lin ? (WT_W'(ONE) - t_ext) : q0;
        w1 = sd.lin ? t_ext : q1;
        for (int k = 0; k < 4; k++)
        begin
            pa_next[k] = $signed(sd.a[k]) * w0;
            pb_next[k] = $signed(sd.b[k]) * w1;
        end
    end

    // round, shift and saturate each component
    always_comb
    begin
        logic signed [ACC_W-1:0]  acc, sh;
        logic signed [COMP_W-1:0] comp [4];
        for (int k = 0; k < 4; k++)
        begin
            acc = ACC_W'(pa_reg[k]) + ACC_W'(pb_reg[k]) + HALF;
            sh  = acc >>> FRAC_BITS;
            if (sh > SAT_HI)
            begin
                comp[k] = COMP_W'(SAT_HI);
            end
            else if (sh < SAT_LO)
            begin
                comp[k] = COMP_W'(SAT_LO);
            end
            else
            begin
                comp[k] = COMP_W'(sh);
            end
        end
        res_next.out_x       = comp[0];
        res_next.out_y       = comp[1];
        res_next.out_z       = comp[2];
        res_next.out_w       = comp[3];
        res_next.used_linear = side_reg[S_WT].lin;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // payload registers, frozen while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg     <= side_next;
            prod_reg     <= prod_next;
            c_reg        <= c_next;
            sq_rem_reg   <= sq_rem_next;
            sq_root_reg  <= sq_root_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            cz_reg       <= cz_next;
            zs_reg       <= zs_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            sz_reg       <= sz_next;
            dv_num_reg   <= dv_num_next;
            dv_rem_reg   <= dv_rem_next;
            dv_sgn_reg   <= dv_sgn_next;
            dv_den_reg   <= dv_den_next;
            pa_reg       <= pa_next;
            pb_reg       <= pb_next;
            res_reg      <= res_next;
        end
    end

    // checks
    `QS_ASSERT(a_sqrt_floor,
        vld_reg[S_SQ_LAST] |-> (TRIAL_W'(sq_rem_reg[S_SQ_LAST])
            <= (TRIAL_W'(sq_root_reg[S_SQ_LAST]) << 1)),
        "square root remainder exceeds 2*root")
    `QS_ASSERT(a_blend_clamped,
        vld_reg[S_WT] |-> (side_reg[S_WT].t <= BLEND_W'(ONE)),
        "blend above one reached the weight stage")
    `QS_ASSERT(a_linear_sticks,
        (en && vld_reg[S_DOT] && side_reg[S_DOT].lin) |=> side_reg[S_RAD].lin,
        "linear flag lost between stages")
    `QS_ASSERT(a_freeze,
        item_stall |=> $stable(vld_reg),
        "pipeline moved while stalled")

endmodule

[tb/quaternion_slerp_top_test.sv]
// Self-checking testbench for quaternion_slerp_top: directed and random slerp transactions.
// Depends on qslerp_pkg and the quaternion_slerp_top RTL.
`timescale 1ns / 1ps

module quaternion_slerp_top_test;

    import qslerp_pkg::*;

    localparam int LATENCY     = 84;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1030;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    item_t   pending_items[$];
    result_t expected_slerps[$];
    int      mismatch_count;
    int      cycle_count;
    int      sent_count;
    int      checked_count;
    int      linear_count;
    int      send_gap;
    int      stall_left;
    bit      stimulus_done;
    bit      drain_hold;

    quaternion_slerp_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // free-running clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // arithmetic shift right with floor
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // atan(2^-i) rounded to FRAC_BITS
    function automatic longint arc_step(int i);
        longint v;
        int sh;
        sh = 30 - FRAC_BITS;
        case (i)
            0:  v = 843314857;
            1:  v = 497837829;
            2:  v = 263043837;
            3:  v = 133525159;
            4:  v = 67021687;
            5:  v = 33543516;
            6:  v = 16775851;
            7:  v = 8388437;
            8:  v = 4194283;
            9:  v = 2097149;
            10: v = 1048576;
            default: v = (i <= 30) ? (longint'(1) << (30 - i)) : 0;
        endcase
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint root_floor(longint v);
        longint r, bitv;
        r = 0;
        bitv = longint'(1) << 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >>> 1) + bitv;
            end
            else
                r = r >>> 1;
            bitv = bitv >>> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += arc_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= arc_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint rotate_sine(longint z);
        longint x, y, dx, dy;
        x = longint'(1) << FRAC_BITS;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arc_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += arc_step(i);
            end
        end
        return y;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // compute the slerp of one transaction
    function automatic result_t slerp_predict(item_t q);
        longint a[4], b[4], dot, t, w0, w1, c, s, omega, tw, so, acc, unit;
        result_t r;
        bit lin;
        unit = longint'(1) << FRAC_BITS;
        a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z; a[3] = q.a_w;
        b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z; b[3] = q.b_w;
        dot = 0;
        for (int k = 0; k < 4; k++)
            dot += a[k] * b[k];
        t = q.blend;
        if (t > unit) t = unit;
        if (dot < 0)
        begin
            dot = -dot;
            for (int k = 0; k < 4; k++)
                b[k] = -b[k];
        end
        c = dot >>> FRAC_BITS;
        lin = !(c < THR);
        w0 = unit - t;
        w1 = t;
        if (!lin)
        begin
            s = root_floor((longint'(1) << (2 * FRAC_BITS)) - c * c);
            omega = vector_angle(s, c);
            tw = (omega * t) >>> FRAC_BITS;
            so = rotate_sine(omega);
            if (so > 0)
            begin
                w0 = (rotate_sine(omega - tw) * unit) / so;
                w1 = (rotate_sine(tw) * unit) / so;
            end
            else
                lin = 1'b1;
        end
        for (int k = 0; k < 4; k++)
        begin
            acc = a[k] * w0 + b[k] * w1 + (longint'(1) << (FRAC_BITS - 1));
            acc = acc >>> FRAC_BITS;
            case (k)
                0: r.out_x = clamp16(acc);
                1: r.out_y = clamp16(acc);
                2: r.out_z = clamp16(acc);
                default: r.out_w = clamp16(acc);
            endcase
        end
        r.used_linear = lin;
        return r;
    endfunction

    function automatic int random_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic signed [15:0] random_comp(int mode);
        case (mode)
            0: return 16'($urandom_range(65535));
            1: return 16'(int'($urandom_range(16384)) - 8192);
            default: return 16'(int'($urandom_range(1024)) - 512);
        endcase
    endfunction

    function automatic item_t make_item(int ax, int ay, int az, int aw,
                                        int bx, int by, int bz, int bw, int t);
        item_t q;
        q.a_x = 16'(ax); q.a_y = 16'(ay); q.a_z = 16'(az); q.a_w = 16'(aw);
        q.b_x = 16'(bx); q.b_y = 16'(by); q.b_z = 16'(bz); q.b_w = 16'(bw);
        q.blend = 15'(t);
        return q;
    endfunction

    // directed cases, then random unit-like and raw quaternions
    initial
    begin
        item_t q;
        int mode, ang, ca, sa;
        real th;
        pending_items.push_back(make_item(16384, 0, 0, 0, 16384, 0, 0, 0, 8192));
        pending_items.push_back(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
        pending_items.push_back(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
        pending_items.push_back(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 8192));
        pending_items.push_back(make_item(16384, 0, 0, 0, -16384, 0, 0, 0, 4096));
        pending_items.push_back(make_item(16384, 0, 0, 0, 11585, -11585, 0, 0, 12000));
        pending_items.push_back(make_item(0, 0, 0, 16384, 0, 0, -16383, 200, 30000));
        pending_items.push_back(make_item(0, 0, 0, 16384, 0, 0, 16383, 0, 32767));
        pending_items.push_back(make_item(0, 0, 0, 16384, 0, 0, 200, 16382, 9000));
        pending_items.push_back(make_item(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, -32768, 16384));
        pending_items.push_back(make_item(32767, 32767, 32767, 32767,
                                          -32768, -32768, -32768, -32768, 8192));
        pending_items.push_back(make_item(32767, -32768, 32767, -32768,
                                          32767, 32767, -32768, -32768, 16385));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 5000));
        pending_items.push_back(make_item(1, -1, 0, 0, -1, 1, 0, 0, 0));
        pending_items.push_back(make_item(8192, 8192, 8192, 8192,
                                          8192, -8192, 8192, -8192, 7000));
        pending_items.push_back(make_item(32767, 0, 0, 0, 0, -32768, 0, 0, 16384));
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            mode = $urandom_range(9);
            if (mode < 6)
            begin
                // unit quaternion pair at a random angle
                ang = $urandom_range(3600);
                th = ang * 3.14159265 / 3600.0;
                ca = int'(16384.0 * $cos(th));
                sa = int'(16384.0 * $sin(th));
                q = make_item(16384, 0, 0, 0, ca, sa, 0, 0, $urandom_range(16384));
                if ($urandom_range(1)) q = make_item(0, 0, 16384, 0, 0, 0, ca, -sa,
                                                     $urandom_range(16384));
            end
            else
            begin
                q.a_x = random_comp(mode - 6); q.a_y = random_comp(mode - 6);
                q.a_z = random_comp(mode - 6); q.a_w = random_comp(mode - 6);
                q.b_x = random_comp(mode - 6); q.b_y = random_comp(mode - 6);
                q.b_z = random_comp(mode - 6); q.b_w = random_comp(mode - 6);
                q.blend = ($urandom_range(9) == 0) ? 15'($urandom_range(32767))
                                                   : 15'($urandom_range(16384));
            end
            pending_items.push_back(q);
        end
    end

    // reset once at the start
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // drive transactions from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            send_gap <= 0;
            drain_hold <= 1'b0;
            stimulus_done <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_slerps.push_back(slerp_predict(item));
                sent_count <= sent_count + 1;
            end
            if (item_valid && item_stall)
            begin
                // hold the stalled payload
            end
            else if (drain_hold)
            begin
                item_valid <= 1'b0;
                if (expected_slerps.size() == 0 && !(item_valid && !item_stall))
                    drain_hold <= 1'b0;
            end
            else if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() > 0)
            begin
                item_valid <= 1'b1;
                item <= pending_items.pop_front();
                send_gap <= random_gap();
                // pause once until the pipeline drains
                if (pending_items.size() == 500)
                    drain_hold <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    // random stall on the result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left <= ($urandom_range(3) == 0) ? random_gap() : 0;
        end
    end

    // compare accepted results with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_slerps.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                want = expected_slerps.pop_front();
                checked_count <= checked_count + 1;
                if (want.used_linear) linear_count <= linear_count + 1;
                if (want !== result)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: expected x=%0d y=%0d z=%0d w=%0d lin=%0d, got x=%0d y=%0d z=%0d w=%0d lin=%0d",
                                 want.out_x, want.out_y, want.out_z, want.out_w,
                                 want.used_linear, result.out_x, result.out_y,
                                 result.out_z, result.out_w, result.used_linear);
                end
            end
        end
    end

    // end of run and timeout
    initial
    begin
        int tail;
        mismatch_count = 0;
        cycle_count = 0;
        sent_count = 0;
        checked_count = 0;
        linear_count = 0;
        tail = 0;
        while (cycle_count < CYCLE_LIMIT && tail < 2 * LATENCY)
        begin
            @(posedge clk);
            cycle_count++;
            if (stimulus_done && expected_slerps.size() == 0)
                tail++;
        end
        if (tail < 2 * LATENCY)
        begin
            $display("CHECK FAILED");
        end
        else
        begin
            $display("Sent %0d slerp transactions, checked %0d results (%0d linear).",
                     sent_count, checked_count, linear_count);
            if (mismatch_count == 0)
                $display("CHECK OK");
            else
                $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[quaternion_slerp_top.f]
+incdir+design
design/qslerp_pkg.sv
design/quaternion_slerp_top.sv
tb/quaternion_slerp_top_test.sv
